>>> hdl/pmsfp_pkg.sv
// ----------------------------------------------------------------------------
// pmsfp_pkg: shared types and constants of the PM sensor frame parser
// Start bytes, body layout, parser phases and the reading slot map.
// ----------------------------------------------------------------------------
package pmsfp_pkg;

   localparam int unsigned BODY_BYTES   = 30;
   localparam int unsigned NUM_READINGS = 9;
   localparam int unsigned SLOT_W       = $clog2(NUM_READINGS);

   localparam logic [7:0] START_ONE = 8'h42;
   localparam logic [7:0] START_TWO = 8'h4d;

   // Last body byte, and the first body byte that is left out of the sum.
   localparam logic [4:0] LAST_IDX    = 5'(BODY_BYTES - 1);
   localparam logic [4:0] SUM_END_IDX = 5'(BODY_BYTES - 2);

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_SECOND = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef logic [15:0] reading_type;
   typedef reading_type reading_array_type [NUM_READINGS];

   typedef struct packed {
      logic              store_we;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       word;
      logic              done;
      logic              status;
   } framer_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } slot_type;

   // Maps the body offset of a reading's low byte to its slot in the store.
   function automatic slot_type slot_of(input logic [4:0] idx);
      slot_type s;
      s.hit  = 1'b1;
      s.slot = '0;
      case (idx)
         5'd3:    s.slot = SLOT_W'(0);
         5'd5:    s.slot = SLOT_W'(1);
         5'd7:    s.slot = SLOT_W'(2);
         5'd15:   s.slot = SLOT_W'(3);
         5'd17:   s.slot = SLOT_W'(4);
         5'd19:   s.slot = SLOT_W'(5);
         5'd21:   s.slot = SLOT_W'(6);
         5'd23:   s.slot = SLOT_W'(7);
         5'd25:   s.slot = SLOT_W'(8);
         default: s.hit  = 1'b0;
      endcase
      return s;
   endfunction

endpackage

>>> hdl/pmsfp_framer.sv
// ----------------------------------------------------------------------------
// pmsfp_framer: byte-level frame tracker
// Hunts for the start bytes, walks the body, keeps the checksum and pairs
// the bytes of each big-endian word.
// ----------------------------------------------------------------------------
module pmsfp_framer
   import pmsfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_byte,
   output framer_ctl_type ctl
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  index_ff, index_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic        last_byte;
   slot_type    slot_hit;

   assign last_byte = (index_ff == LAST_IDX);
   assign slot_hit  = slot_of(index_ff);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_SECOND: phase_in = (rx_byte == START_TWO) ? PH_BODY : PH_HUNT;
            PH_BODY:   phase_in = last_byte ? PH_HUNT : PH_BODY;
            default:   phase_in = (rx_byte == START_ONE) ? PH_SECOND : PH_HUNT;
         endcase
      end
   end

   // Counters, checksum and the pending high byte.
   always_comb begin
      index_in = index_ff;
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      if (accept) begin
         case (phase_ff)
            PH_SECOND: begin
               if (rx_byte == START_TWO) begin
                  sum_in   = sum_ff + {8'h00, rx_byte};
                  index_in = '0;
               end
            end
            PH_BODY: begin
               if (index_ff < SUM_END_IDX) begin
                  sum_in = sum_ff + {8'h00, rx_byte};
               end
               if (!index_ff[0]) begin
                  hold_in = rx_byte;
               end
               index_in = last_byte ? 5'd0 : index_ff + 5'd1;
            end
            default: begin
               if (rx_byte == START_ONE) begin
                  sum_in = {8'h00, rx_byte};
               end
            end
         endcase
      end
   end

   // Store write and frame completion.
   always_comb begin
      ctl.word     = {hold_ff, rx_byte};
      ctl.slot     = slot_hit.slot;
      ctl.store_we = accept && (phase_ff == PH_BODY) && index_ff[0] && slot_hit.hit;
      ctl.done     = accept && (phase_ff == PH_BODY) && last_byte;
      ctl.status   = (sum_ff != {hold_ff, rx_byte});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         index_ff <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

>>> hdl/pmsfp_store.sv
// ----------------------------------------------------------------------------
// pmsfp_store: reading store
// Nine 16-bit readings, one written per completed word pair that maps to a slot.
// ----------------------------------------------------------------------------
module pmsfp_store
   import pmsfp_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [SLOT_W-1:0] slot,
   input  reading_type       word,
   output reading_array_type readings
);

   reading_array_type store_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[slot] <= word;
      end
   end

   assign readings = store_ff;

endmodule

>>> hdl/pm_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// pm_sensor_frame_parser: serial frame parser for a particulate sensor
// Takes received bytes and gives the nine readings of each frame with a
// checksum status.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on req_ carries one received byte. One byte is taken per
//   cycle while req_ready is high. After the two start bytes and a 30-byte
//   body, one result is placed on rsp_ in the cycle after the last body
//   byte is taken. Bytes that do not complete a frame give no result.
//   rsp_frame_status is 0 when the wrapping 16-bit sum of the start bytes
//   and body bytes 0 to 27 equals the word in body bytes 28 and 29.
//   The result sits in an output register. While it waits and rsp_ready is
//   low, req_ready is low; when the result is taken in a cycle, a new byte
//   can be taken in that same cycle, so the rate stays one byte per cycle.
//   Reset returns the parser to hunting for the first start byte, clears
//   the checksum and drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pm_sensor_frame_parser
   import pmsfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_mass_pm1,
   output logic [15:0] rsp_mass_pm25,
   output logic [15:0] rsp_mass_pm10,
   output logic [15:0] rsp_count_03um,
   output logic [15:0] rsp_count_05um,
   output logic [15:0] rsp_count_1um,
   output logic [15:0] rsp_count_25um,
   output logic [15:0] rsp_count_5um,
   output logic [15:0] rsp_count_10um,
   output logic        rsp_frame_status
);

   logic              accept;
   framer_ctl_type    ctl;
   reading_array_type readings;

   logic              rsp_valid_ff, rsp_valid_in;
   reading_array_type result_ff;
   logic              status_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   pmsfp_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .ctl     (ctl)
   );

   pmsfp_store u_store (
      .clock    (clock),
      .we       (ctl.store_we),
      .slot     (ctl.slot),
      .word     (ctl.word),
      .readings (readings)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Every reading is written earlier in the frame than its last byte.
   always_ff @(posedge clock) begin
      if (ctl.done) begin
         result_ff <= readings;
         status_ff <= ctl.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mass_pm1     = result_ff[0];
   assign rsp_mass_pm25    = result_ff[1];
   assign rsp_mass_pm10    = result_ff[2];
   assign rsp_count_03um   = result_ff[3];
   assign rsp_count_05um   = result_ff[4];
   assign rsp_count_1um    = result_ff[5];
   assign rsp_count_25um   = result_ff[6];
   assign rsp_count_5um    = result_ff[7];
   assign rsp_count_10um   = result_ff[8];
   assign rsp_frame_status = status_ff;

   // A result appears only after a byte was taken in the previous cycle.
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result raised without a request");

   // A finished frame always leaves a result pending.
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.done |=> rsp_valid_ff)
      else $error("completed frame produced no result");

   // A stalled result must block new requests so it is never overwritten.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !ctl.done && !ctl.store_we)
      else $error("state changed while a result was stalled");

endmodule

>>> test/pm_sensor_frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_sensor_frame_parser_checker: frame predictor and result checker
// Watches the request and result channels of the parser. Each accepted byte
// is run through a cycle-free model of the frame parser, and each finished
// frame is queued. Every accepted result is compared, field by field, with
// the oldest queued frame.
// ----------------------------------------------------------------------------
module pm_sensor_frame_parser_checker
   import pmsfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_mass_pm1,
   input  logic [15:0] rsp_mass_pm25,
   input  logic [15:0] rsp_mass_pm10,
   input  logic [15:0] rsp_count_03um,
   input  logic [15:0] rsp_count_05um,
   input  logic [15:0] rsp_count_1um,
   input  logic [15:0] rsp_count_25um,
   input  logic [15:0] rsp_count_5um,
   input  logic [15:0] rsp_count_10um,
   input  logic        rsp_frame_status,
   output int unsigned mismatch_count,
   output int unsigned frames_pending
);

   typedef struct packed {
      logic [NUM_READINGS-1:0][15:0] readings;
      logic                          status;
   } frame_result_type;

   phase_type        parse_phase;
   logic [4:0]       body_pos;
   logic [15:0]      frame_sum;
   logic [7:0]       pair_high;
   reading_type      latched [NUM_READINGS];
   frame_result_type expected_frames [$];
   frame_result_type want;

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // Advances the frame parser by one received byte and queues the frame
   // result when the last body byte arrives.
   task automatic parse_byte(input logic [7:0] rx);
      logic [15:0]      word;
      frame_result_type result;
      word = {pair_high, rx};
      case (parse_phase)
         PH_SECOND: begin
            if (rx == START_TWO) begin
               frame_sum   = frame_sum + 16'(rx);
               body_pos    = '0;
               parse_phase = PH_BODY;
            end else begin
               // The rejected byte is not looked at again as a start byte.
               parse_phase = PH_HUNT;
            end
         end
         PH_BODY: begin
            if (body_pos < SUM_END_IDX) begin
               frame_sum = frame_sum + 16'(rx);
            end
            // Even offsets hold the high byte of a pair; the reading is
            // complete on the odd offset that follows.
            if (!body_pos[0]) begin
               pair_high = rx;
            end else if (body_pos >= 5'd3 && body_pos <= 5'd7) begin
               latched[(body_pos - 5'd3) >> 1] = word;
            end else if (body_pos >= 5'd15 && body_pos <= 5'd25) begin
               latched[3 + ((body_pos - 5'd15) >> 1)] = word;
            end
            if (body_pos == LAST_IDX) begin
               for (int k = 0; k < NUM_READINGS; k++) begin
                  result.readings[k] = latched[k];
               end
               result.status = (frame_sum != word);
               expected_frames.push_back(result);
               parse_phase = PH_HUNT;
               body_pos    = '0;
            end else begin
               body_pos = body_pos + 5'd1;
            end
         end
         default: begin
            if (rx == START_ONE) begin
               frame_sum   = 16'(rx);
               parse_phase = PH_SECOND;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_phase = PH_HUNT;
         body_pos    = '0;
         frame_sum   = '0;
         pair_high   = '0;
         for (int k = 0; k < NUM_READINGS; k++) begin
            latched[k] = '0;
         end
         expected_frames.delete();
      end else begin
         // A result can never come from the byte taken at the same edge, so
         // compare before predicting.
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("frame result with no frame expected");
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("mass_pm1", want.readings[0], rsp_mass_pm1);
               check_field("mass_pm25", want.readings[1], rsp_mass_pm25);
               check_field("mass_pm10", want.readings[2], rsp_mass_pm10);
               check_field("count_03um", want.readings[3], rsp_count_03um);
               check_field("count_05um", want.readings[4], rsp_count_05um);
               check_field("count_1um", want.readings[5], rsp_count_1um);
               check_field("count_25um", want.readings[6], rsp_count_25um);
               check_field("count_5um", want.readings[7], rsp_count_5um);
               check_field("count_10um", want.readings[8], rsp_count_10um);
               check_field("frame_status", 16'(want.status), 16'(rsp_frame_status));
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
         end
      end
      frames_pending <= expected_frames.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the PM sensor frame parser
// Feeds stray bytes, broken start sequences, truncated and complete frames
// with good and bad checksums, under random idling on both channels and one
// long stall of the result channel. The checker beside the block predicts
// and compares every frame result.
// ----------------------------------------------------------------------------
module tb
   import pmsfp_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned MIN_BYTES   = 900;
   localparam int unsigned MIN_FRAMES  = 25;
   localparam int unsigned DRAIN_WAIT  = 10;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [15:0] rsp_mass_pm1;
   logic [15:0] rsp_mass_pm25;
   logic [15:0] rsp_mass_pm10;
   logic [15:0] rsp_count_03um;
   logic [15:0] rsp_count_05um;
   logic [15:0] rsp_count_1um;
   logic [15:0] rsp_count_25um;
   logic [15:0] rsp_count_5um;
   logic [15:0] rsp_count_10um;
   logic        rsp_frame_status;

   int unsigned mismatch_count;
   int unsigned frames_pending;

   bit          idling_on   = 1'b1;
   bit          hold_wanted = 1'b0;
   bit          hold_done   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent  = 0;
   int unsigned frames_sent = 0;
   logic [7:0]  frame_body [BODY_BYTES];

   pm_sensor_frame_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mass_pm1     (rsp_mass_pm1),
      .rsp_mass_pm25    (rsp_mass_pm25),
      .rsp_mass_pm10    (rsp_mass_pm10),
      .rsp_count_03um   (rsp_count_03um),
      .rsp_count_05um   (rsp_count_05um),
      .rsp_count_1um    (rsp_count_1um),
      .rsp_count_25um   (rsp_count_25um),
      .rsp_count_5um    (rsp_count_5um),
      .rsp_count_10um   (rsp_count_10um),
      .rsp_frame_status (rsp_frame_status)
   );

   pm_sensor_frame_parser_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mass_pm1     (rsp_mass_pm1),
      .rsp_mass_pm25    (rsp_mass_pm25),
      .rsp_mass_pm10    (rsp_mass_pm10),
      .rsp_count_03um   (rsp_count_03um),
      .rsp_count_05um   (rsp_count_05um),
      .rsp_count_1um    (rsp_count_1um),
      .rsp_count_25um   (rsp_count_25um),
      .rsp_count_5um    (rsp_count_5um),
      .rsp_count_10um   (rsp_count_10um),
      .rsp_frame_status (rsp_frame_status),
      .mismatch_count   (mismatch_count),
      .frames_pending   (frames_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** pm_sensor_frame_parser: FAILED **");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off once it is asked for.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= idling_on ? ($urandom_range(99) >= 36) : 1'b1;
      end
   end

   // Offers one byte and returns at the edge where the request is taken.
   // Ready is looked at on the falling edge, where it is settled.
   task automatic send_byte(input logic [7:0] rx);
      while (idling_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic fill_body(input bit random_fill, input logic [7:0] value);
      for (int i = 0; i < BODY_BYTES; i++) begin
         frame_body[i] = random_fill ? 8'($urandom) : value;
      end
   endtask

   // Sends a whole frame; the checksum word is correct or deliberately off.
   task automatic send_frame(input bit sum_ok);
      logic [15:0] sum;
      sum = 16'(START_ONE) + 16'(START_TWO);
      for (int i = 0; i < BODY_BYTES - 2; i++) begin
         sum = sum + 16'(frame_body[i]);
      end
      if (!sum_ok) begin
         sum = sum ^ 16'($urandom_range(65535, 1));
      end
      frame_body[BODY_BYTES-2] = sum[15:8];
      frame_body[BODY_BYTES-1] = sum[7:0];
      send_byte(START_ONE);
      send_byte(START_TWO);
      for (int i = 0; i < BODY_BYTES; i++) begin
         send_byte(frame_body[i]);
      end
   endtask

   initial begin
      int unsigned pick;
      logic [7:0]  bad_second;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Stray bytes while hunting, including a lone second start byte.
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(START_TWO);
      // Bad second start byte, then a repeated first start byte that must
      // not be taken as a new start.
      send_byte(START_ONE);
      send_byte(8'h00);
      send_byte(START_ONE);
      send_byte(START_ONE);
      send_byte(START_TWO);
      // Largest readings, smallest readings with a bad checksum, random.
      fill_body(1'b0, 8'hff);
      send_frame(1'b1);
      fill_body(1'b0, 8'h00);
      send_frame(1'b0);
      fill_body(1'b1, 8'h00);
      send_frame(1'b1);

      while (bytes_sent < MIN_BYTES || frames_sent < MIN_FRAMES) begin
         if (frames_sent == 12) idling_on <= 1'b0;
         if (frames_sent == 18) idling_on <= 1'b1;
         if (frames_sent == 24) hold_wanted <= 1'b1;
         pick = $urandom_range(99);
         if (pick < 75) begin
            fill_body($urandom_range(9) != 0, $urandom_range(1) ? 8'hff : 8'h00);
            send_frame($urandom_range(3) != 0);
            frames_sent++;
         end else if (pick < 85) begin
            repeat ($urandom_range(8, 1)) begin
               send_byte(($urandom_range(3) == 0) ? START_ONE : 8'($urandom));
            end
         end else if (pick < 93) begin
            bad_second = $urandom_range(1) ? START_ONE : 8'($urandom);
            if (bad_second == START_TWO) bad_second = 8'h00;
            send_byte(START_ONE);
            send_byte(bad_second);
         end else begin
            // A frame cut short; the bytes after it run on as its body.
            send_byte(START_ONE);
            send_byte(START_TWO);
            repeat ($urandom_range(BODY_BYTES - 2, 1)) send_byte(8'($urandom));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** pm_sensor_frame_parser: PASSED **");
      end else begin
         $display("** pm_sensor_frame_parser: FAILED **");
      end
      $finish;
   end

endmodule
